[hw/rtl/occupancy_slot_table_defines.svh]
// Assertion macros shared by the slot table RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef OCCUPANCY_SLOT_TABLE_DEFINES_SVH
`define OCCUPANCY_SLOT_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ost_pkg.sv]
package ost_pkg;

    // default table geometry
    localparam int SLOT_COUNT_DEF = 256;
    localparam int ITEM_WIDTH_DEF = 32;

    // beat field widths
    localparam int MODE_W      = 2;
    localparam int SLOT_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // operation codes carried in s_tuser; code 3 is a no-op
    typedef enum logic [MODE_W-1:0] {
        MODE_READ = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_FREE = 2'd2
    } mode_t;

endpackage

[hw/rtl/ost_ram.sv]
module ost_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/occupancy_slot_table.sv]
// Path: s_* -> s1_* compute stage registers -> output register -> m_*. Throughput:
// one beat per cycle unless m_tready stalls; first-free search and range clear work on
// the whole occupancy bitmap in the single compute stage, and the item RAM has one port
// each way. Reset: rst_n clears the occupancy bitmap (every slot free) and the pipeline
// valids; no clearing pass, item RAM data is used only where the occupancy bit is set.
`include "occupancy_slot_table_defines.svh"

module occupancy_slot_table
    import ost_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // slot_index [7:0], range_end [15:8], item_value [47:16]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode [1:0]
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_value [31:0], placed_slot [39:32], was_occupied [40], status [41]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int EXT_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    // input side
    logic             s_accept;
    logic [EXT_W-1:0] in_idx;
    logic [IDX_W-1:0] ram_rd_addr;

    // compute stage registers
    logic                  s1_valid_reg;
    mode_t                 s1_mode_reg;
    logic [EXT_W-1:0]      s1_idx_reg;
    logic [EXT_W-1:0]      s1_end_reg;
    logic [ITEM_WIDTH-1:0] s1_item_reg;
    logic                  fwd_hit_reg;
    logic                  fwd_hit_next;
    logic [ITEM_WIDTH-1:0] fwd_data_reg;
    logic                  s1_fire;

    // occupancy bitmap
    logic [SLOT_COUNT-1:0] bitmap_reg;
    logic [SLOT_COUNT-1:0] bitmap_next;

    // first-free search
    logic [SLOT_COUNT-1:0] free_vec;
    logic [SLOT_COUNT-1:0] lowest_free;
    logic [IDX_W-1:0]      first_idx;
    logic                  table_full;

    // range clear
    logic [EXT_W-1:0]      range_lo;
    logic [EXT_W-1:0]      range_hi;
    logic [EXT_W-1:0]      range_hi_sat;
    logic [SLOT_COUNT-1:0] clr_mask;

    // read path
    logic                  rd_in_range;
    logic                  rd_occ;
    logic [ITEM_WIDTH-1:0] ram_rd_data;
    logic [ITEM_WIDTH-1:0] rd_item;

    // item RAM write
    logic ram_wr_en;

    // result
    logic [VALUE_W-1:0]     res_read_value;
    logic [SLOT_W-1:0]      res_placed_slot;
    logic                   res_was_occupied;
    logic                   res_status;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_ready;

    // handshake: the output register frees the compute stage, which frees the input
    assign out_ready = !out_valid_reg || m_tready;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    assign in_idx      = EXT_W'(s_tdata[SLOT_W-1:0]);
    assign ram_rd_addr = IDX_W'(in_idx);

    // lowest free slot: isolate the lowest set bit of the free vector, then encode it
    assign free_vec    = ~bitmap_reg;
    assign lowest_free = free_vec & (~free_vec + SLOT_COUNT'(1));
    assign table_full  = ~|free_vec;

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (lowest_free[i])
            begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

    // range clear mask: order the ends, saturate the top, build a band of ones
    always_comb
    begin
        if (s1_idx_reg > s1_end_reg)
        begin
            range_lo = s1_end_reg;
            range_hi = s1_idx_reg;
        end
        else
        begin
            range_lo = s1_idx_reg;
            range_hi = s1_end_reg;
        end
        range_hi_sat = (range_hi > EXT_W'(SLOT_COUNT - 1)) ? EXT_W'(SLOT_COUNT - 1) : range_hi;
        clr_mask = ({SLOT_COUNT{1'b1}} << range_lo)
                 & ({SLOT_COUNT{1'b1}} >> (EXT_W'(SLOT_COUNT - 1) - range_hi_sat));
    end

    // read: occupancy check, RAM data with bypass of a same-slot write
    assign rd_in_range = s1_idx_reg < EXT_W'(SLOT_COUNT);
    assign rd_occ      = rd_in_range && bitmap_reg[s1_idx_reg[IDX_W-1:0]];
    assign rd_item     = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    assign ram_wr_en    = s1_fire && (s1_mode_reg == MODE_ADD) && !table_full;
    assign fwd_hit_next = ram_wr_en && (first_idx == ram_rd_addr);

    ost_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (first_idx),
        .wr_data (s1_item_reg),
        .rd_en   (s_accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result fields and bitmap update per mode
    always_comb
    begin
        res_read_value   = '0;
        res_placed_slot  = '0;
        res_was_occupied = 1'b0;
        res_status       = 1'b0;
        bitmap_next      = bitmap_reg;
        case (s1_mode_reg)
            MODE_READ:
            begin
                if (rd_occ)
                begin
                    res_read_value   = VALUE_W'(rd_item);
                    res_was_occupied = 1'b1;
                end
            end
            MODE_ADD:
            begin
                if (table_full)
                begin
                    res_status = 1'b1;
                end
                else
                begin
                    res_placed_slot = SLOT_W'(first_idx);
                    bitmap_next     = bitmap_reg | lowest_free;
                end
            end
            MODE_FREE:
            begin
                bitmap_next = bitmap_reg & ~clr_mask;
            end
            default:
            begin
                bitmap_next = bitmap_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bitmap_reg    <= '0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                bitmap_reg    <= bitmap_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_mode_reg  <= mode_t'(s_tuser);
            s1_idx_reg   <= in_idx;
            s1_end_reg   <= EXT_W'(s_tdata[2*SLOT_W-1:SLOT_W]);
            s1_item_reg  <= ITEM_WIDTH'(s_tdata[2*SLOT_W+VALUE_W-1:2*SLOT_W]);
            fwd_data_reg <= s1_item_reg;
        end
        if (s1_fire)
        begin
            out_data_reg <= OUT_TDATA_W'({res_status, res_was_occupied,
                                          res_placed_slot, res_read_value});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `OST_ASSERT_NEXT(a_add_marks_slot, ram_wr_en, bitmap_reg[$past(first_idx)],
        "add did not mark its slot occupied")
    `OST_ASSERT_NEXT(a_free_clears_range, s1_fire && (s1_mode_reg == MODE_FREE),
        (bitmap_reg & $past(clr_mask)) == '0, "range free left a slot occupied")
    `OST_ASSERT_NOW(a_full_has_no_slot, s1_fire && (s1_mode_reg == MODE_ADD) && table_full,
        !ram_wr_en && (&bitmap_reg), "full table took a write")
    `OST_ASSERT_NOW(a_stall_means_full_pipe, !s_tready,
        s1_valid_reg && out_valid_reg && !m_tready, "input stalled with room in the pipe")

endmodule
